// ===== rtl/core/jrsp_pkg.sv =====
// Shared constants for the joystick rate servo position unit.
// No dependencies; imported by the unit, by its port checkers and by the bench.
`default_nettype none
package jrsp_pkg;

   // Position in 1/256 units; full travel 5000 is 1280000
   localparam int unsigned POS_W = 21;
   localparam logic [POS_W-1:0] POS_FULL = 21'd1280000;
   localparam logic [POS_W-1:0] POS_MID  = 21'd640000;

   localparam int unsigned SAMPLE_W = 10;
   localparam logic [SAMPLE_W-1:0] HIGH_EDGE = 10'd520;
   localparam logic [SAMPLE_W-1:0] LOW_EDGE  = 10'd510;

   // Rising step 512*d/504 = d + floor(d/63)
   localparam int unsigned HIGH_DIV = 63;
   // Falling step 512*e/510 = e + floor(e/255)
   localparam int unsigned LOW_DIV  = 255;

   // Compare scaling: m/1280000 = (m >> 11)/625, the latter by reciprocal
   localparam int unsigned PROD_W      = 29;
   localparam int unsigned FRAC_SHIFT  = 11;
   localparam int unsigned QIN_W       = PROD_W - FRAC_SHIFT;
   localparam logic [QIN_W-1:0] RECIP_MUL = 18'd214749;
   localparam int unsigned RECIP_SHIFT = 27;
   localparam logic [PROD_W-1:0] CEIL_ADD = 29'd1279999;

   localparam int unsigned CFG_W = 8;

   // Register indexes (byte address bit 2)
   localparam logic REG_SERVO_MIN = 1'b0;
   localparam logic REG_SERVO_MAX = 1'b1;

   localparam logic [CFG_W-1:0] SERVO_MIN_RST = 8'd7;
   localparam logic [CFG_W-1:0] SERVO_MAX_RST = 8'd39;

endpackage
`default_nettype wire

// ===== rtl/core/joystick_rate_servo_position_unit.sv =====
// Joystick rate servo position unit: two-axis position integrator and
// PWM compare scaling. Depends on jrsp_pkg.
//
// Usage:
//  - req_ channel: one 10-bit joystick reading per item. Readings alternate
//    between axis 0 and axis 1, starting with axis 0 after reset.
//  - rsp_ channel: one item per reading: the axis (tuser), the updated
//    position in 1/256 units and the PWM compare value (tdata).
//  - csr_ port: servo_min at byte address 0, servo_max at byte address 4.
//    Only to be written while no item is in flight.
// Timing: five-stage pipeline (input, integrate, multiply, reciprocal
// scale, output). One item per cycle is sustained while results are
// taken, limited by nothing but the stage registers. Each axis is read
// back two items later at the earliest, after its integrate stage has
// already written it.
// Reset: both positions return to mid travel, the axis select to axis 0,
// servo_min/max to 7/39, and the pipeline empties.
// Stall: each stage holds only if the one after it is full and held, so
// bubbles close up and readings keep being taken while a result waits.
`default_nettype none
module joystick_rate_servo_position_unit
   import jrsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,   // [9:0] sample, [15:10] zero
   // result items
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [20:0] position, [28:21] compare_value
   output      logic [0:0]  rsp_tuser,   // [0] axis
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   // ---------------- configuration registers ----------------
   logic [CFG_W-1:0] servo_min_ff, servo_max_ff;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         servo_min_ff <= SERVO_MIN_RST;
         servo_max_ff <= SERVO_MAX_RST;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_SERVO_MIN: servo_min_ff <= csr_pwdata[CFG_W-1:0];
            REG_SERVO_MAX: servo_max_ff <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[2])
         REG_SERVO_MIN: csr_prdata[CFG_W-1:0] = servo_min_ff;
         REG_SERVO_MAX: csr_prdata[CFG_W-1:0] = servo_max_ff;
         default:       csr_prdata = '0;
      endcase
   end

   // Falling compare when servo_max is below servo_min; span is |max-min|
   logic             desc;
   logic [CFG_W-1:0] span;
   assign desc = servo_max_ff < servo_min_ff;
   assign span = desc ? (servo_min_ff - servo_max_ff) : (servo_max_ff - servo_min_ff);

   // ---------------- pipeline control ----------------
   logic v0_ff, v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic en0, en1, en2, en3, en_o;

   assign en_o = !rsp_valid_ff || rsp_tready;
   assign en3  = !v3_ff || en_o;
   assign en2  = !v2_ff || en3;
   assign en1  = !v1_ff || en2;
   assign en0  = !v0_ff || en1;

   assign req_tready = en0;

   // ---------------- axis and position state ----------------
   logic             axis_select_ff;
   logic [POS_W-1:0] pos_first_ff, pos_second_ff;

   // stage payloads
   logic [SAMPLE_W-1:0] s0_sample_ff;
   logic                s0_axis_ff;
   logic                s1_axis_ff, s2_axis_ff, s3_axis_ff, rsp_axis_ff;
   logic [POS_W-1:0]    s1_pos_ff, s2_pos_ff, s3_pos_ff, rsp_pos_ff;
   logic [PROD_W-1:0]   s2_m_ff;
   logic [CFG_W-1:0]    s3_q_ff, rsp_cmp_ff;

   // ---------------- integrate stage logic ----------------
   logic [8:0]       d_up, e_dn;
   logic [2:0]       q_up;
   logic [9:0]       inc, dec;
   logic [POS_W-1:0] pos_old, pos_in;
   logic [POS_W:0]   pos_sum;

   always_comb begin
      pos_old = s0_axis_ff ? pos_second_ff : pos_first_ff;
      d_up    = 9'(s0_sample_ff - HIGH_EDGE);
      e_dn    = 9'(LOW_EDGE - s0_sample_ff);
      // floor(d/63), d at most 503: count thresholds passed
      q_up = '0;
      for (int k = 1; k <= 7; k++) begin
         if (d_up >= 9'(k * HIGH_DIV)) q_up = q_up + 3'd1;
      end
      inc = {1'b0, d_up} + {7'd0, q_up};
      // floor(e/255), e at most 510
      dec = {1'b0, e_dn} + 10'(e_dn >= 9'(LOW_DIV)) + 10'(e_dn >= 9'(2 * LOW_DIV));
      pos_sum = {1'b0, pos_old} + {{(POS_W-9){1'b0}}, inc};
      pos_in  = pos_old;
      if (s0_sample_ff > HIGH_EDGE) begin
         pos_in = (pos_sum > {1'b0, POS_FULL}) ? POS_FULL : pos_sum[POS_W-1:0];
      end else if (s0_sample_ff < LOW_EDGE) begin
         pos_in = ({{(POS_W-10){1'b0}}, dec} >= pos_old) ? '0
                  : pos_old - {{(POS_W-10){1'b0}}, dec};
      end
   end

   // ---------------- scaling stage logic ----------------
   logic [PROD_W-1:0]      m_in;
   logic [2*QIN_W-1:0]     recip_prod;
   logic [CFG_W-1:0]       q_in, cmp_in;

   // pos*span at full product width, biased up for the ceiling in the falling case
   assign m_in = PROD_W'(s1_pos_ff) * PROD_W'(span) + (desc ? CEIL_ADD : '0);
   // floor(y/625) for y below 2^18 via reciprocal
   assign recip_prod = s2_m_ff[PROD_W-1:FRAC_SHIFT] * RECIP_MUL;
   assign q_in       = recip_prod[RECIP_SHIFT +: CFG_W];
   assign cmp_in     = desc ? (servo_min_ff - s3_q_ff) : (servo_min_ff + s3_q_ff);

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff          <= 1'b0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         axis_select_ff <= 1'b0;
         pos_first_ff   <= POS_MID;
         pos_second_ff  <= POS_MID;
      end else begin
         if (en0) v0_ff <= req_tvalid;
         if (en1) v1_ff <= v0_ff;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en_o) rsp_valid_ff <= v3_ff;
         if (req_tvalid && en0) axis_select_ff <= !axis_select_ff;
         // axis state is written as the item leaves the input stage
         if (en1 && v0_ff) begin
            if (s0_axis_ff) pos_second_ff <= pos_in;
            else            pos_first_ff  <= pos_in;
         end
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (en0) begin
         s0_sample_ff <= req_tdata[SAMPLE_W-1:0];
         s0_axis_ff   <= axis_select_ff;
      end
      if (en1) begin
         s1_axis_ff <= s0_axis_ff;
         s1_pos_ff  <= pos_in;
      end
      if (en2) begin
         s2_axis_ff <= s1_axis_ff;
         s2_pos_ff  <= s1_pos_ff;
         s2_m_ff    <= m_in;
      end
      if (en3) begin
         s3_axis_ff <= s2_axis_ff;
         s3_pos_ff  <= s2_pos_ff;
         s3_q_ff    <= q_in;
      end
      if (en_o) begin
         rsp_axis_ff <= s3_axis_ff;
         rsp_pos_ff  <= s3_pos_ff;
         rsp_cmp_ff  <= cmp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_cmp_ff, rsp_pos_ff};
   assign rsp_tuser  = rsp_axis_ff;

endmodule
`default_nettype wire

// ===== rtl/core/jrsp_checker.sv =====
// Port-level checker for the joystick rate servo position unit, with bind.
// Depends on jrsp_pkg and joystick_rate_servo_position_unit.
`default_nettype none
module jrsp_port_assertions
   import jrsp_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   // axis the next result item should carry
   logic exp_axis_ff;

   always_ff @(posedge clock) begin
      if (reset) exp_axis_ff <= 1'b0;
      else if (rsp_tvalid && rsp_tready) exp_axis_ff <= !exp_axis_ff;
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_axis_alternates: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[0] == exp_axis_ff)
      else $error("result axis out of sequence");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[POS_W-1:0] <= POS_FULL)
      else $error("position beyond full travel");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind joystick_rate_servo_position_unit jrsp_port_assertions u_jrsp_port_assertions (.*);
`default_nettype wire

// ===== dv/jrsp_checker.sv =====
`timescale 1ns / 1ps
// Port checker for the joystick rate servo position unit: mirrors the item
// flow and the CSR port and compares every result. Depends on jrsp_pkg.
module jrsp_checker
   import jrsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] sample, [15:10] zero
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [20:0] position, [28:21] compare_value
   input  logic [0:0]  rsp_tuser,   // [0] axis
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          results_owed
);

   localparam int unsigned RATE_SCALE = 512;
   localparam int unsigned RISE_SPAN  = 504;
   localparam int unsigned FALL_SPAN  = 510;

   typedef struct packed {
      logic             axis;
      logic [POS_W-1:0] position;
      logic [CFG_W-1:0] compare_value;
   } servo_result_type;

   servo_result_type predicted_results [$];
   logic             axis_sel;
   logic [POS_W-1:0] axis_pos [2];
   logic [CFG_W-1:0] lo_limit;
   logic [CFG_W-1:0] hi_limit;
   int               errors = 0;

   // rate integration with dead zone, clamped to zero and to full travel
   function automatic logic [POS_W-1:0] integrate_position(input logic [POS_W-1:0] pos,
                                                          input logic [SAMPLE_W-1:0] s);
      int unsigned level;
      int unsigned step;
      level = pos;
      if (s > HIGH_EDGE) begin
         step  = (RATE_SCALE * (32'(s) - 32'(HIGH_EDGE))) / RISE_SPAN;
         level = level + step;
         if (level > 32'(POS_FULL))
            level = POS_FULL;
      end else if (s < LOW_EDGE) begin
         step  = (RATE_SCALE * (32'(LOW_EDGE) - 32'(s))) / FALL_SPAN;
         level = (step >= level) ? 0 : level - step;
      end
      return POS_W'(level);
   endfunction

   // floor of the exact compare value, whichever way the limits lie
   function automatic logic [CFG_W-1:0] pwm_compare(input logic [POS_W-1:0] pos,
                                                   input logic [CFG_W-1:0] lo,
                                                   input logic [CFG_W-1:0] hi);
      longint unsigned full;
      longint unsigned prod;
      full = 64'(POS_FULL);
      if (hi >= lo) begin
         prod = 64'(pos) * 64'(hi - lo);
         return lo + CFG_W'(prod / full);
      end
      prod = 64'(pos) * 64'(lo - hi);
      return lo - CFG_W'((prod + full - 1) / full);
   endfunction

   always @(posedge clock) begin
      servo_result_type seen;
      servo_result_type want;
      logic [CFG_W-1:0] held;
      if (reset) begin
         predicted_results.delete();
         axis_sel    = 1'b0;
         axis_pos[0] = POS_MID;
         axis_pos[1] = POS_MID;
         lo_limit    = SERVO_MIN_RST;
         hi_limit    = SERVO_MAX_RST;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == REG_SERVO_MIN)
                  lo_limit = csr_pwdata[CFG_W-1:0];
               else
                  hi_limit = csr_pwdata[CFG_W-1:0];
            end else begin
               held = (csr_paddr[2] == REG_SERVO_MIN) ? lo_limit : hi_limit;
               if (csr_prdata !== {24'd0, held}) begin
                  $error("prdata: expected %0d, got %0d", held, csr_prdata);
                  errors++;
               end
            end
         end
         // results before readings, so a result never meets its own reading
         if (rsp_tvalid && rsp_tready) begin
            seen = {rsp_tuser[0], rsp_tdata[20:0], rsp_tdata[28:21]};
            if (predicted_results.size() == 0) begin
               $error("result item with none expected");
               errors++;
            end else begin
               want = predicted_results.pop_front();
               if (seen.axis !== want.axis) begin
                  $error("axis: expected %0d, got %0d", want.axis, seen.axis);
                  errors++;
               end
               if (seen.position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, seen.position);
                  errors++;
               end
               if (seen.compare_value !== want.compare_value) begin
                  $error("compare_value: expected %0d, got %0d",
                         want.compare_value, seen.compare_value);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            axis_pos[axis_sel] = integrate_position(axis_pos[axis_sel],
                                                    req_tdata[SAMPLE_W-1:0]);
            predicted_results.push_back({axis_sel, axis_pos[axis_sel],
                                         pwm_compare(axis_pos[axis_sel], lo_limit, hi_limit)});
            axis_sel = ~axis_sel;
         end
      end
      mismatch_count <= errors;
      results_owed   <= predicted_results.size();
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the joystick rate servo position unit bench: clock, reset, stimulus
// and verdict. Depends on jrsp_pkg, the unit and jrsp_checker.
module testbench;
   import jrsp_pkg::*;

   // kinds of reading stream a phase produces
   typedef enum {SAMPLES_MIXED, SAMPLES_LOW, SAMPLES_HIGH} sample_mix_type;

   // Directed readings: field extremes, both dead zone edges, the values just
   // inside (on both axes) and outside them, and alternating bit patterns.
   localparam logic [SAMPLE_W-1:0] DIRECTED [20] = '{
      10'd0, 10'd1023, 10'd509, 10'd510, 10'd520, 10'd521, 10'd515, 10'd515,
      10'd519, 10'd511, 10'd511, 10'd519, 10'd1, 10'd1022, 10'd341, 10'd682,
      10'd512, 10'd255, 10'd768, 10'd508
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [9:0] sample, [15:10] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [20:0] position, [28:21] compare_value
   logic [0:0]  rsp_tuser;        // [0] axis
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          mismatch_count;
   int          results_owed;

   // per-side ceiling on the idle cycles drawn before each item
   int unsigned req_gap_max = 10;
   int unsigned rsp_gap_max = 10;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   joystick_rate_servo_position_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   jrsp_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   // Reading generator. Sweeps push hard one way; a fifth of their items
   // are drawn as in the mixed stream.
   function automatic logic [SAMPLE_W-1:0] pick_sample(input sample_mix_type mix);
      if (mix != SAMPLES_MIXED && $urandom_range(0, 9) < 8)
         return (mix == SAMPLES_HIGH) ? SAMPLE_W'($urandom_range(940, 1023))
                                      : SAMPLE_W'($urandom_range(0, 80));
      case ($urandom_range(0, 4))
         0:       return SAMPLE_W'($urandom_range(500, 530));   // around dead zone
         1:       return SAMPLE_W'($urandom_range(0, 20));
         2:       return SAMPLE_W'($urandom_range(1003, 1023));
         default: return SAMPLE_W'($urandom_range(0, 1023));
      endcase
   endfunction

   // One reading; valid is held over into the next item when no gap is drawn.
   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, s};
      do @(posedge clock); while (!req_tready);
   endtask

   // Setup then access cycle, then the port returns to idle.
   task automatic csr_access(input bit write, input logic index,
                             input logic [CFG_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {24'($urandom()), value};   // upper bits are don't-care
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Stop readings and let the pipeline drain before touching the CSRs.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_limits(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
      settle();
      csr_access(1'b1, REG_SERVO_MIN, lo);
      csr_access(1'b1, REG_SERVO_MAX, hi);
      csr_access(1'b0, REG_SERVO_MIN, '0);
      csr_access(1'b0, REG_SERVO_MAX, '0);
   endtask

   task automatic run_phase(input int count, input sample_mix_type mix,
                            input int unsigned req_max, input int unsigned rsp_max);
      req_gap_max = req_max;
      rsp_gap_max = rsp_max;
      repeat (count) send_sample(pick_sample(mix));
   endtask

   // Result side: random stall before each item, ready held across items
   // when no stall is drawn.
   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_gap_max);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      int drain_cycles;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of the limits, then the directed readings
      csr_access(1'b0, REG_SERVO_MIN, '0);
      csr_access(1'b0, REG_SERVO_MAX, '0);
      foreach (DIRECTED[i]) send_sample(DIRECTED[i]);

      set_limits(8'd0, 8'd255);
      run_phase(100, SAMPLES_MIXED, 10, 10);
      // reversed limits with both sides flat out
      set_limits(8'd255, 8'd0);
      run_phase(100, SAMPLES_MIXED, 0, 0);
      // push both axes downward
      set_limits(8'd20, 8'd240);
      run_phase(60, SAMPLES_LOW, 10, 10);
      set_limits(8'd250, 8'd5);
      run_phase(60, SAMPLES_MIXED, 10, 0);
      // then push them back up
      set_limits(8'd5, 8'd250);
      run_phase(60, SAMPLES_HIGH, 10, 10);
      set_limits(8'd255, 8'd0);
      run_phase(30, SAMPLES_HIGH, 0, 10);
      set_limits(8'd0, 8'd0);
      run_phase(30, SAMPLES_MIXED, 10, 10);
      set_limits(8'd255, 8'd255);
      run_phase(30, SAMPLES_MIXED, 10, 10);
      repeat (4) begin
         set_limits(CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)));
         run_phase(15, SAMPLES_MIXED, 10, 10);
      end

      // drain with a bound; anything still owed after it is a failure
      req_tvalid <= 1'b0;
      @(posedge clock);
      for (drain_cycles = 0; results_owed != 0 && drain_cycles < 2000; drain_cycles++)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
